// ----- src/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock edge, off during reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on the rising clock edge, also during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/bsc_pkg.sv -----
// types and constants for the barometric compensation core
`default_nettype none

package bsc_pkg;

  localparam int unsigned DIV_W  = 32;
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 64;

  // register indexes, byte address is 8 times the index
  typedef enum logic [2:0] {
    REG_CAL_A = 3'd0,
    REG_CAL_B = 3'd1,
    REG_CAL_C = 3'd2,
    REG_CAL_D = 3'd3,
    REG_OSS   = 3'd4
  } reg_idx_t;

  // compensation constants
  localparam logic [31:0] C_B6_OFF  = 32'd4000;
  localparam logic [31:0] C_B7_BASE = 32'd50000;
  localparam logic [31:0] C_B4_OFF  = 32'd32768;
  localparam logic [31:0] C_P_SQ    = 32'd3038;
  localparam logic [31:0] C_P_LIN   = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] C_P_OFF   = 32'd3791;
  localparam logic [31:0] C_T_RND   = 32'd8;
  localparam logic [31:0] C_RND2    = 32'd2;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [18:0] raw_press;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] temp_tenths;
    logic signed [31:0] pressure_pa;
    logic               divide_fault;
  } out_beat_t;

  // calibration set as seen by the datapath
  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
    logic [1:0]  oss;
  } cal_t;

  // sign extend a 16-bit coefficient
  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  // arithmetic right shift of a 32-bit word
  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    asr = $signed(x) >>> n;
  endfunction

endpackage

`default_nettype wire

// ----- src/barometric_sensor_compensation_core.sv -----
// top level of the barometric compensation pipeline
//
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid/in_stall  | in_data (raw_temp, raw_press)
//  out     | source    | out_valid/out_stall| out_data (temp, pressure, fault)
//  apb     | slave     | psel/penable/pready| paddr, pwdata, prdata
//
// one beat accepted per cycle while the output is not stalled
// the two 32-stage dividers, one quotient bit per stage, make up most of the latency
// the whole pipeline freezes while a result sits in the output register stalled
// rst is synchronous and clears all valid bits and the calibration registers
`default_nettype none
`include "assert_macros.svh"

module barometric_sensor_compensation_core import bsc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_beat_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_beat_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned SIDE1_W = 32 + 19 + 2;
  localparam int unsigned SIDE2_W = 32 + 2;

  cal_t cal;
  logic adv;

  bsc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cal
  );

  // pipeline moves unless a finished beat is held at the output
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 1: first temperature product
  logic        v1;
  logic [31:0] s1_m;
  logic [18:0] s1_up;
  logic [31:0] d1;
  assign d1 = {16'b0, in_data.raw_temp} - {16'b0, cal.ac6};

  // stage 2: divisor and operand magnitudes
  logic        v2;
  logic [31:0] s2_x1, s2_nmag, s2_dmag;
  logic [18:0] s2_up;
  logic        s2_neg, s2_zero;
  logic [31:0] x1_2, den_2, num_2;
  assign x1_2  = asr(s1_m, 5'd15);
  assign den_2 = x1_2 + sx16(cal.md);
  assign num_2 = sx16(cal.mc) << 11;

  // first divider
  logic                v_d1;
  logic [31:0]         q1;
  logic [SIDE1_W-1:0]  side1;
  logic [31:0]         d1_x1;
  logic [18:0]         d1_up;
  logic                d1_neg, d1_fault;
  assign {d1_x1, d1_up, d1_neg, d1_fault} = side1;

  bsc_div #(.SIDE_W(SIDE1_W)) u_div_t (
    .clk, .rst, .en(adv), .in_vld(v2), .num(s2_nmag), .den(s2_dmag),
    .in_side({s2_x1, s2_up, s2_neg, s2_zero}),
    .out_vld(v_d1), .quo(q1), .out_side(side1)
  );

  // stage 3: b5, temperature, b6
  logic        v3;
  logic [31:0] s3_t, s3_b6;
  logic [18:0] s3_up;
  logic        s3_fault;
  logic [31:0] b5_3;
  assign b5_3 = d1_x1 + (d1_neg ? 32'(-q1) : q1);

  // stage 4: products on b6
  logic        v4;
  logic [31:0] s4_sqp, s4_p2, s4_p3, s4_t;
  logic [18:0] s4_up;
  logic        s4_fault;

  // stage 5: scaled terms
  logic        v5;
  logic [31:0] s5_sq, s5_x2a, s5_x1c, s5_t;
  logic [18:0] s5_up;
  logic        s5_fault;

  // stage 6: products on sq
  logic        v6;
  logic [31:0] s6_m1, s6_m2, s6_x2a, s6_x1c, s6_t;
  logic [18:0] s6_up;
  logic        s6_fault;

  // stage 7: b3 and x3
  logic        v7;
  logic [31:0] s7_b3, s7_x3, s7_t;
  logic [18:0] s7_up;
  logic        s7_fault;
  logic [31:0] x3_7, b3_7;
  assign x3_7 = asr(s6_m1, 5'd11) + s6_x2a;
  assign b3_7 = asr((((sx16(cal.ac1) << 2) + x3_7) << cal.oss) + C_RND2, 5'd2);

  // stage 8: b4 and pressure difference
  logic        v8;
  logic [31:0] s8_b4, s8_diff, s8_t;
  logic        s8_fault;

  // stage 9: b7
  logic        v9;
  logic [31:0] s9_b7, s9_b4, s9_t;
  logic        s9_fault;

  // second divider
  logic                v_d2;
  logic [31:0]         q2;
  logic [SIDE2_W-1:0]  side2;
  logic [31:0]         d2_t;
  logic                d2_hi, d2_fault;
  assign {d2_t, d2_hi, d2_fault} = side2;

  bsc_div #(.SIDE_W(SIDE2_W)) u_div_p (
    .clk, .rst, .en(adv), .in_vld(v9),
    .num(s9_b7[31] ? s9_b7 : (s9_b7 << 1)), .den(s9_b4),
    .in_side({s9_t, s9_b7[31], s9_fault}),
    .out_vld(v_d2), .quo(q2), .out_side(side2)
  );

  // stage 10: pressure products
  logic        v10;
  logic [31:0] s10_p, s10_sqq, s10_m7, s10_t;
  logic        s10_fault;
  logic [31:0] p_10, a_10;
  assign p_10 = d2_hi ? (q2 << 1) : q2;
  assign a_10 = asr(p_10, 5'd8);

  // stage 11: square term scaled
  logic        v11;
  logic [31:0] s11_p, s11_m3, s11_x2, s11_t;
  logic        s11_fault;

  // final pressure correction
  logic [31:0] pout;
  assign pout = s11_p + asr(asr(s11_m3, 5'd16) + s11_x2 + C_P_OFF, 5'd4);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0; v11 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v_d1; v4 <= v3; v5 <= v4; v6 <= v5;
      v7 <= v6; v8 <= v7; v9 <= v8; v10 <= v_d2; v11 <= v10;
      out_valid <= v11;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_m  <= d1 * {16'b0, cal.ac5};
      s1_up <= in_data.raw_press;

      s2_x1   <= x1_2;
      s2_up   <= s1_up;
      s2_nmag <= num_2[31] ? 32'(-num_2) : num_2;
      s2_dmag <= den_2[31] ? 32'(-den_2) : den_2;
      s2_neg  <= num_2[31] ^ den_2[31];
      s2_zero <= (den_2 == '0);

      s3_t     <= asr(b5_3 + C_T_RND, 5'd4);
      s3_b6    <= b5_3 - C_B6_OFF;
      s3_up    <= d1_up;
      s3_fault <= d1_fault;

      s4_sqp   <= s3_b6 * s3_b6;
      s4_p2    <= sx16(cal.ac2) * s3_b6;
      s4_p3    <= sx16(cal.ac3) * s3_b6;
      s4_t     <= s3_t;
      s4_up    <= s3_up;
      s4_fault <= s3_fault;

      s5_sq    <= asr(s4_sqp, 5'd12);
      s5_x2a   <= asr(s4_p2, 5'd11);
      s5_x1c   <= asr(s4_p3, 5'd13);
      s5_t     <= s4_t;
      s5_up    <= s4_up;
      s5_fault <= s4_fault;

      s6_m1    <= sx16(cal.b2) * s5_sq;
      s6_m2    <= sx16(cal.b1) * s5_sq;
      s6_x2a   <= s5_x2a;
      s6_x1c   <= s5_x1c;
      s6_t     <= s5_t;
      s6_up    <= s5_up;
      s6_fault <= s5_fault;

      s7_b3    <= b3_7;
      s7_x3    <= asr(s6_x1c + asr(s6_m2, 5'd16) + C_RND2, 5'd2);
      s7_t     <= s6_t;
      s7_up    <= s6_up;
      s7_fault <= s6_fault;

      s8_b4    <= ({16'b0, cal.ac4} * (s7_x3 + C_B4_OFF)) >> 15;
      s8_diff  <= {13'b0, s7_up} - s7_b3;
      s8_t     <= s7_t;
      s8_fault <= s7_fault;

      s9_b7    <= s8_diff * (C_B7_BASE >> cal.oss);
      s9_b4    <= s8_b4;
      s9_t     <= s8_t;
      s9_fault <= s8_fault || (s8_b4 == '0);

      s10_p     <= p_10;
      s10_sqq   <= a_10 * a_10;
      s10_m7    <= C_P_LIN * p_10;
      s10_t     <= d2_t;
      s10_fault <= d2_fault;

      s11_p     <= s10_p;
      s11_m3    <= s10_sqq * C_P_SQ;
      s11_x2    <= asr(s10_m7, 5'd16);
      s11_t     <= s10_t;
      s11_fault <= s10_fault;

      out_data.temp_tenths  <= s11_fault ? '0 : s11_t;
      out_data.pressure_pa  <= s11_fault ? '0 : pout;
      out_data.divide_fault <= s11_fault;
    end
  end

  // checks
  `ASSERT_CLK(a_fault_zero, clk, rst,
    out_valid && out_data.divide_fault |-> out_data.temp_tenths == 0 && out_data.pressure_pa == 0,
    "fault beat carries nonzero results")
  `ASSERT_CLK(a_stall_back, clk, rst, out_valid && out_stall |-> in_stall,
    "input taken while output is held")
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid,
    "result valid right after reset")

endmodule

`default_nettype wire

// ----- src/bsc_regs.sv -----
// apb register file holding the calibration words and oversampling
`default_nettype none

module bsc_regs import bsc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic      [DATA_W-1:0]   prdata,
  output logic                     pready,
  output cal_t                     cal
);

  logic [47:0] cal_a;
  logic [47:0] cal_b;
  logic [31:0] cal_c;
  logic [31:0] cal_d;
  logic [1:0]  oss;
  reg_idx_t    idx;
  logic        wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_a <= '0;
      cal_b <= '0;
      cal_c <= '0;
      cal_d <= '0;
      oss   <= '0;
    end else if (wr) begin
      case (idx)
        REG_CAL_A: cal_a <= pwdata[47:0];
        REG_CAL_B: cal_b <= pwdata[47:0];
        REG_CAL_C: cal_c <= pwdata[31:0];
        REG_CAL_D: cal_d <= pwdata[31:0];
        REG_OSS:   oss   <= pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_CAL_A: prdata = {16'b0, cal_a};
      REG_CAL_B: prdata = {16'b0, cal_b};
      REG_CAL_C: prdata = {32'b0, cal_c};
      REG_CAL_D: prdata = {32'b0, cal_d};
      REG_OSS:   prdata = {62'b0, oss};
      default:   prdata = '0;
    endcase
  end

  // unpack coefficients
  assign cal.ac1 = cal_a[47:32];
  assign cal.ac2 = cal_a[31:16];
  assign cal.ac3 = cal_a[15:0];
  assign cal.ac4 = cal_b[47:32];
  assign cal.ac5 = cal_b[31:16];
  assign cal.ac6 = cal_b[15:0];
  assign cal.b1  = cal_c[31:16];
  assign cal.b2  = cal_c[15:0];
  assign cal.mc  = cal_d[31:16];
  assign cal.md  = cal_d[15:0];
  assign cal.oss = oss;

endmodule

`default_nettype wire

// ----- src/bsc_div.sv -----
// pipelined unsigned restoring divider, one quotient bit per stage
`default_nettype none

module bsc_div import bsc_pkg::*; #(
  parameter int unsigned SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_vld,
  input  wire logic [DIV_W-1:0]  num,
  input  wire logic [DIV_W-1:0]  den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_vld,
  output logic      [DIV_W-1:0]  quo,
  output logic      [SIDE_W-1:0] out_side
);

  logic              vld   [DIV_W];
  logic [DIV_W-1:0]  rem_r [DIV_W];
  logic [DIV_W-1:0]  num_r [DIV_W];
  logic [DIV_W-1:0]  den_r [DIV_W];
  logic [SIDE_W-1:0] side_r[DIV_W];

  logic [DIV_W-1:0]  rem_n [DIV_W];
  logic [DIV_W-1:0]  num_n [DIV_W];

  // one trial subtract per stage
  always_comb begin
    for (int s = 0; s < DIV_W; s++) begin
      logic [DIV_W-1:0] r_in;
      logic [DIV_W-1:0] n_in;
      logic [DIV_W-1:0] d_in;
      logic [DIV_W:0]   sh;
      logic             ge;
      r_in = (s == 0) ? '0  : rem_r[(s == 0) ? 0 : s-1];
      n_in = (s == 0) ? num : num_r[(s == 0) ? 0 : s-1];
      d_in = (s == 0) ? den : den_r[(s == 0) ? 0 : s-1];
      sh   = {r_in, n_in[DIV_W-1]};
      ge   = sh >= {1'b0, d_in};
      rem_n[s] = ge ? DIV_W'(sh - {1'b0, d_in}) : sh[DIV_W-1:0];
      num_n[s] = {n_in[DIV_W-2:0], ge};
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_W; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
      for (int s = 1; s < DIV_W; s++) vld[s] <= vld[s-1];
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_W; s++) begin
        rem_r[s] <= rem_n[s];
        num_r[s] <= num_n[s];
      end
      den_r[0]  <= den;
      side_r[0] <= in_side;
      for (int s = 1; s < DIV_W; s++) begin
        den_r[s]  <= den_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign out_vld  = vld[DIV_W-1];
  assign quo      = num_r[DIV_W-1];
  assign out_side = side_r[DIV_W-1];

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// testbench for the barometric compensation core: scoreboard class and stimulus
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import bsc_pkg::*;

  // scoreboard holding the compensated readings still owed by the core
  class comp_scoreboard;
    logic [47:0] cal_a, cal_b;
    logic [31:0] cal_c, cal_d;
    logic [1:0]  oss;
    out_beat_t   owed[$];
    int          mismatches;
    int          checked;

    function new();
      cal_a = '0; cal_b = '0; cal_c = '0; cal_d = '0; oss = '0;
      mismatches = 0; checked = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [63:0] v);
      case (idx)
        REG_CAL_A: cal_a = v[47:0];
        REG_CAL_B: cal_b = v[47:0];
        REG_CAL_C: cal_c = v[31:0];
        REG_CAL_D: cal_d = v[31:0];
        REG_OSS:   oss = v[1:0];
        default: ;
      endcase
    endfunction

    static function logic [31:0] sra(logic [31:0] x, int n);
      return $signed(x) >>> n;
    endfunction

    static function logic [31:0] ext(logic [15:0] v);
      return {{16{v[15]}}, v};
    endfunction

    // integer compensation of one raw reading pair
    function out_beat_t compensate(in_beat_t b);
      out_beat_t r;
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] ut, up, x1, x2, x3, b5, b6, b3, b4, b7, sq, p, t, den;
      longint q;
      ac1 = ext(cal_a[47:32]); ac2 = ext(cal_a[31:16]); ac3 = ext(cal_a[15:0]);
      ac4 = {16'b0, cal_b[47:32]}; ac5 = {16'b0, cal_b[31:16]}; ac6 = {16'b0, cal_b[15:0]};
      b1 = ext(cal_c[31:16]); b2 = ext(cal_c[15:0]);
      mc = ext(cal_d[31:16]); md = ext(cal_d[15:0]);
      ut = {16'b0, b.raw_temp}; up = {13'b0, b.raw_press};
      r.temp_tenths = 0; r.pressure_pa = 0; r.divide_fault = 1'b1;
      x1 = sra((ut - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 0) return r;
      q = longint'($signed(mc << 11)) / longint'($signed(den));
      x2 = q[31:0];
      b5 = x1 + x2;
      t = sra(b5 + 32'd8, 4);
      b6 = b5 - 32'd4000;
      sq = sra(b6 * b6, 12);
      x1 = sra(b2 * sq, 11);
      x2 = sra(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = sra(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
      x1 = sra(ac3 * b6, 13);
      x2 = sra(b1 * sq, 16);
      x3 = sra(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      if (b4 == 0) return r;
      b7 = (up - b3) * (32'd50000 >> oss);
      if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
      else p = (b7 / b4) << 1;
      x1 = sra(p, 8) * sra(p, 8);
      x1 = sra(x1 * 32'd3038, 16);
      x2 = sra((32'd0 - 32'd7357) * p, 16);
      p = p + sra(x1 + x2 + 32'd3791, 4);
      r.temp_tenths = t; r.pressure_pa = p; r.divide_fault = 1'b0;
      return r;
    endfunction

    function void note_input(in_beat_t b);
      owed.push_back(compensate(b));
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t exp_r;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = owed.pop_front();
      checked++;
      if (got.temp_tenths !== exp_r.temp_tenths || got.pressure_pa !== exp_r.pressure_pa ||
          got.divide_fault !== exp_r.divide_fault) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp t=%0d p=%0d f=%0b got t=%0d p=%0d f=%0b",
                   exp_r.temp_tenths, exp_r.pressure_pa, exp_r.divide_fault,
                   got.temp_tenths, got.pressure_pa, got.divide_fault);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  comp_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  bit stall_mode = 0;
  localparam int LIMIT = 400000;
  localparam int LATENCY = 76;

  barometric_sensor_compensation_core dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  // cycle limit and result sampling
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver stall pattern, switched between quiet and busy stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    out_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
  end

  task automatic reg_write(reg_idx_t idx, logic [63:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(8 * int'(idx)); pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // one beat; with hold set, valid stays high across back-to-back beats
  task automatic send_beat(logic [15:0] ut, logic [18:0] up, bit hold);
    in_beat_t b;
    b.raw_temp = ut; b.raw_press = up;
    in_valid <= 1'b1; in_data <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
    sent++;
    @(negedge clk);
    if (!hold) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic drain();
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_all(logic [47:0] a, logic [47:0] b, logic [31:0] c, logic [31:0] d,
                         logic [1:0] o);
    reg_write(REG_CAL_A, 64'(a)); reg_write(REG_CAL_B, 64'(b));
    reg_write(REG_CAL_C, 64'(c)); reg_write(REG_CAL_D, 64'(d));
    reg_write(REG_OSS, 64'(o));
  endtask

  // random burst of beats with gaps
  task automatic random_phase(int n, bit wide);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && n > 0) begin
        if (wide)
          send_beat(16'($urandom), 19'($urandom), burst > 1 && n > 1);
        else
          send_beat(16'($urandom_range(20000, 40000)), 19'($urandom_range(20000, 100000)),
                    burst > 1 && n > 1);
        burst--; n--;
      end
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset calibration: zero divisors give the fault
    send_beat(16'h0000, 19'h00000, 1'b0);
    send_beat(16'hFFFF, 19'h7FFFF, 1'b0);
    drain();

    // typical datasheet calibration, field extremes at each oversampling
    for (int o = 0; o < 4; o++) begin
      set_all({16'd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd32757, 16'd23153},
              {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'(o));
      send_beat(16'd27898, 19'd23843, 1'b1);
      send_beat(16'h0000, 19'h00000, 1'b1);
      send_beat(16'hFFFF, 19'h7FFFF, 1'b1);
      send_beat(16'hAAAA, 19'h55555, 1'b0);
      send_beat(16'h5555, 19'h2AAAA, 1'b0);
      drain();
    end

    // zero temperature divisor: md is zero and x1 is zero with ac5 zero
    set_all('0, 48'h0000_0000_0000, 32'd0, {16'd100, 16'd0}, 2'd0);
    send_beat(16'd1234, 19'd1000, 1'b0);
    drain();
    // zero pressure divisor: ac4 zero
    set_all({16'd408, 16'd0, 16'd0}, {16'd0, 16'd32757, 16'd23153}, 32'd0,
            {16'd5, 16'd2868}, 2'd1);
    send_beat(16'd27898, 19'd23843, 1'b0);
    drain();
    // most negative mc over a divisor of minus one
    set_all('0, {16'd1, 16'd0, 16'd0}, 32'd0, {16'h8000, 16'hFFFF}, 2'd0);
    send_beat(16'd0, 19'd0, 1'b0);
    drain();
    // all-ones extremes
    set_all({48{1'b1}}, {48{1'b1}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
    send_beat(16'hFFFF, 19'h7FFFF, 1'b0);
    send_beat(16'h0000, 19'h00000, 1'b0);
    drain();

    // random phases: mostly realistic calibration, some fully random words
    for (int ph = 0; ph < 13; ph++) begin
      if (ph % 3 == 2)
        set_all(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom, $urandom,
                2'($urandom));
      else
        set_all({16'($urandom_range(200, 9000)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535))},
                {16'($urandom_range(20000, 40000)), 16'($urandom_range(20000, 40000)),
                 16'($urandom_range(10000, 30000))},
                $urandom, {16'($urandom_range(32768, 60000)), 16'($urandom_range(1000, 5000))},
                2'($urandom));
      random_phase(100, ph % 2 == 0);
      drain();
    end

    $display("sent %0d reading pairs over 13 random calibrations and directed corners", sent);
    $display("checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
